[sv/mtcd_pkg.sv]
// Package for the minutes-to-calendar-date unit: calendar constants, the
// sequencer state type, the serial divider control struct and the month table.
// No dependencies.
package mtcd_pkg;

  localparam int DATE_BITS_DEFAULT = 32;

  localparam int MIN_PER_DAY      = 1440;
  localparam int MIN_PER_HOUR     = 60;
  localparam int DAYS_PER_CYCLE   = 1461;
  localparam int DAYS_LEAP_YEAR   = 366;
  localparam int DAYS_COMMON_YEAR = 365;

  // Remainders below 1461 and minute-of-day values below 1440 fit in 11 bits.
  localparam int DAY_REM_BITS  = 11;
  localparam int HOUR_REM_BITS = 6;

  // Index of December; the month walk never goes past it.
  localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DAY,
    ST_SETUP,
    ST_CYCLE,
    ST_YEAR,
    ST_YRED,
    ST_MONTH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } sdiv_ctrl_t;

  // Length of month mo (0 is January) in days.
  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    case (mo)
      4'd1: len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[sv/mtcd_serial_div.sv]
// Bit-serial restoring divider by a constant: one dividend bit per step.
// Depends on mtcd_pkg for the control struct.
module mtcd_serial_div #(
  parameter int DIVIDEND_BITS = 32,
  parameter int REM_BITS      = 11
) (
  input  logic                     clk,
  input  mtcd_pkg::sdiv_ctrl_t     ctrl,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [REM_BITS-1:0]      divisor,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic [REM_BITS-1:0]      remainder
);

  logic [DIVIDEND_BITS-1:0] shreg;
  logic [REM_BITS-1:0]      rem;
  logic [REM_BITS:0]        trial;
  logic [REM_BITS:0]        diff;
  logic                     ge;

  // The dividend leaves at the top while quotient bits enter at the bottom.
  assign trial = {rem, shreg[DIVIDEND_BITS-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      shreg <= dividend;
      rem   <= '0;
    end else if (ctrl.step) begin
      shreg <= {shreg[DIVIDEND_BITS-2:0], ge};
      rem   <= ge ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
    end
  end

  assign quotient  = shreg;
  assign remainder = rem;

endmodule

[sv/minutes_to_calendar_date_unit.sv]
// Top level of the minutes-to-calendar-date unit.
// Depends on mtcd_pkg and mtcd_serial_div.

// Converts a count of minutes since 1980-01-01 00:00 into month, day of month,
// hour and minute, using the every-fourth-year leap rule with no century
// exception. One transaction is worked on at a time, paced by the bit-serial
// dividers: the minute count is divided by 1440 one bit per cycle, then the
// day count is reduced modulo 1461 one bit per cycle while the minute of the
// day is split into hour and minute alongside it, and a year and month walk
// follows. The result sits in an output register, so a new transaction is
// taken as soon as the sequencer is idle, even while the previous result
// still waits to be taken.
module minutes_to_calendar_date_unit #(
  parameter int DATE_BITS = mtcd_pkg::DATE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] minutes_since_1980,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute
);

  // The day count is below 2^DATE_BITS / 1440, so it needs ten fewer bits.
  localparam int DAY_BITS  = DATE_BITS - 10;
  localparam int MOD_BITS  = mtcd_pkg::DAY_REM_BITS;
  localparam int HR_BITS   = mtcd_pkg::HOUR_REM_BITS;
  localparam int CYC_STEPS = (DAY_BITS > MOD_BITS) ? DAY_BITS : MOD_BITS;
  localparam int CNT_BITS  = $clog2(DATE_BITS + 1);

  mtcd_pkg::state_t state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic [MOD_BITS-1:0] d, d_next;
  logic [3:0]          mo, mo_next;
  logic                leap, leap_next;
  logic                out_load;

  mtcd_pkg::sdiv_ctrl_t day_ctrl, cyc_ctrl, hr_ctrl;

  logic [DATE_BITS-1:0] day_quot;
  logic [MOD_BITS-1:0]  day_rem;
  logic [DAY_BITS-1:0]  cyc_quot;
  logic [MOD_BITS-1:0]  cyc_rem;
  logic [MOD_BITS-1:0]  hr_quot;
  logic [HR_BITS-1:0]   hr_rem;
  logic [4:0]           len;

  // Minutes to whole days; the remainder is the minute of the day.
  mtcd_serial_div #(
    .DIVIDEND_BITS(DATE_BITS),
    .REM_BITS     (MOD_BITS)
  ) u_div_day (
    .clk      (clk),
    .ctrl     (day_ctrl),
    .dividend (minutes_since_1980[DATE_BITS-1:0]),
    .divisor  (MOD_BITS'(mtcd_pkg::MIN_PER_DAY)),
    .quotient (day_quot),
    .remainder(day_rem)
  );

  // Day count reduced to the day within the current 4-year cycle.
  mtcd_serial_div #(
    .DIVIDEND_BITS(DAY_BITS),
    .REM_BITS     (MOD_BITS)
  ) u_div_cycle (
    .clk      (clk),
    .ctrl     (cyc_ctrl),
    .dividend (day_quot[DAY_BITS-1:0]),
    .divisor  (MOD_BITS'(mtcd_pkg::DAYS_PER_CYCLE)),
    .quotient (cyc_quot),
    .remainder(cyc_rem)
  );

  // Minute of the day split into hour and minute.
  mtcd_serial_div #(
    .DIVIDEND_BITS(MOD_BITS),
    .REM_BITS     (HR_BITS)
  ) u_div_hour (
    .clk      (clk),
    .ctrl     (hr_ctrl),
    .dividend (day_rem),
    .divisor  (HR_BITS'(mtcd_pkg::MIN_PER_HOUR)),
    .quotient (hr_quot),
    .remainder(hr_rem)
  );

  assign in_ready = (state == mtcd_pkg::ST_IDLE);
  assign len      = mtcd_pkg::month_len(mo, leap);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mtcd_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d    <= d_next;
    mo   <= mo_next;
    leap <= leap_next;
    if (out_load) begin
      month        <= mo + 4'd1;
      day_of_month <= d[4:0] + 5'd1;
      hour         <= hr_quot[4:0];
      minute       <= hr_rem;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    d_next     = d;
    mo_next    = mo;
    leap_next  = leap;
    out_load   = 1'b0;
    day_ctrl   = '0;
    cyc_ctrl   = '0;
    hr_ctrl    = '0;
    case (state)
      mtcd_pkg::ST_IDLE: begin
        if (in_valid) begin
          day_ctrl.load = 1'b1;
          cnt_next      = CNT_BITS'(DATE_BITS - 1);
          state_next    = mtcd_pkg::ST_DAY;
        end
      end
      mtcd_pkg::ST_DAY: begin
        day_ctrl.step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = mtcd_pkg::ST_SETUP;
        end
      end
      mtcd_pkg::ST_SETUP: begin
        cyc_ctrl.load = 1'b1;
        hr_ctrl.load  = 1'b1;
        cnt_next      = CNT_BITS'(CYC_STEPS - 1);
        state_next    = mtcd_pkg::ST_CYCLE;
      end
      mtcd_pkg::ST_CYCLE: begin
        // Each divider takes its last steps so that both finish together.
        cyc_ctrl.step = (cnt < CNT_BITS'(DAY_BITS));
        hr_ctrl.step  = (cnt < CNT_BITS'(MOD_BITS));
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = mtcd_pkg::ST_YEAR;
        end
      end
      mtcd_pkg::ST_YEAR: begin
        mo_next = '0;
        if (cyc_rem < MOD_BITS'(mtcd_pkg::DAYS_LEAP_YEAR)) begin
          leap_next  = 1'b1;
          d_next     = cyc_rem;
          state_next = mtcd_pkg::ST_MONTH;
        end else begin
          leap_next  = 1'b0;
          d_next     = cyc_rem - MOD_BITS'(mtcd_pkg::DAYS_LEAP_YEAR);
          state_next = mtcd_pkg::ST_YRED;
        end
      end
      mtcd_pkg::ST_YRED: begin
        // At most two more common years remain in the cycle.
        if (d >= MOD_BITS'(mtcd_pkg::DAYS_COMMON_YEAR)) begin
          d_next = d - MOD_BITS'(mtcd_pkg::DAYS_COMMON_YEAR);
        end else begin
          state_next = mtcd_pkg::ST_MONTH;
        end
      end
      mtcd_pkg::ST_MONTH: begin
        if ((mo < mtcd_pkg::LAST_MONTH_IDX) && (d >= MOD_BITS'(len))) begin
          d_next  = d - MOD_BITS'(len);
          mo_next = mo + 4'd1;
        end else if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = mtcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtcd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[tb/minutes_to_calendar_date_checker.sv]
// Checker for the minutes-to-calendar-date unit: watches both handshake channels,
// predicts each conversion and compares every returned date field by field.
// Depends only on its ports; no package types are needed.
module minutes_to_calendar_date_checker #(
  parameter int DATE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] minutes_since_1980,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  month,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  output int          mismatches,
  output int          pending,
  output int          dates_checked,
  output int          leap_days_seen,
  output int          december_seen
);

  localparam logic [31:0] MINUTES_PER_DAY   = 32'd1440;
  localparam logic [31:0] MINUTES_PER_HOUR  = 32'd60;
  localparam logic [31:0] DAYS_IN_CYCLE     = 32'd1461;
  localparam logic [31:0] DAYS_IN_LEAP_YEAR = 32'd366;
  localparam logic [31:0] DAYS_IN_YEAR      = 32'd365;
  localparam logic [3:0]  FEBRUARY          = 4'd1;
  localparam logic [3:0]  DECEMBER          = 4'd11;
  localparam int          REPORT_LIMIT      = 10;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] mday;
    logic [4:0] hour;
    logic [5:0] minute;
  } cal_date_t;

  cal_date_t   expected_dates [$];
  logic [31:0] source_minutes [$];
  int          fail_n;
  int          checked_n;
  int          leap_n;
  int          dec_n;

  // Splits a minute count into month, day, hour and minute. Leap years follow
  // the plain every-fourth-year rule, so a four-year cycle is always 1461 days.
  function automatic cal_date_t calendar_of(input logic [31:0] mins);
    logic [63:0] kept;
    logic [31:0] days;
    logic [31:0] min_of_day;
    logic [31:0] d;
    logic [3:0]  mo;
    logic        leap_year;
    logic        found;
    logic [31:0] len;
    cal_date_t   r;
    kept       = {32'd0, mins} & ((64'd1 << DATE_BITS) - 64'd1);
    days       = kept[31:0] / MINUTES_PER_DAY;
    min_of_day = kept[31:0] % MINUTES_PER_DAY;
    d          = days % DAYS_IN_CYCLE;
    leap_year  = (d < DAYS_IN_LEAP_YEAR);
    if (!leap_year) begin
      d = (d - DAYS_IN_LEAP_YEAR) % DAYS_IN_YEAR;
    end
    mo    = 4'd0;
    found = 1'b0;
    while (!found && mo < DECEMBER) begin
      case (mo)
        FEBRUARY:                len = leap_year ? 32'd29 : 32'd28;
        4'd3, 4'd5, 4'd8, 4'd10: len = 32'd30;
        default:                 len = 32'd31;
      endcase
      if (d < len) begin
        found = 1'b1;
      end else begin
        d  = d - len;
        mo = mo + 4'd1;
      end
    end
    r.month  = mo + 4'd1;
    r.mday   = d[4:0] + 5'd1;
    r.hour   = 5'(min_of_day / MINUTES_PER_HOUR);
    r.minute = 6'(min_of_day % MINUTES_PER_HOUR);
    return r;
  endfunction

  always @(posedge clk) begin
    cal_date_t   want;
    cal_date_t   got;
    logic [31:0] src;
    if (!rst) begin
      // Retire the result first so that a date never meets its own prediction
      // pushed in the same cycle.
      if (out_valid && out_ready) begin
        got = '{month, day_of_month, hour, minute};
        if (expected_dates.size() == 0) begin
          fail_n++;
          if (fail_n <= REPORT_LIMIT) begin
            $display("checker: unexpected date %0d/%0d %0d:%0d with nothing pending",
                     month, day_of_month, hour, minute);
          end
        end else begin
          want = expected_dates.pop_front();
          src  = source_minutes.pop_front();
          checked_n++;
          if (got !== want) begin
            fail_n++;
            if (fail_n <= REPORT_LIMIT) begin
              $display("checker: minutes 0x%08h expected %0d/%0d %0d:%0d got %0d/%0d %0d:%0d",
                       src, want.month, want.mday, want.hour, want.minute,
                       month, day_of_month, hour, minute);
            end
          end
          if (want.month == FEBRUARY + 4'd1 && want.mday == 5'd29) begin
            leap_n++;
          end
          if (want.month == DECEMBER + 4'd1) begin
            dec_n++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_dates.push_back(calendar_of(minutes_since_1980));
        source_minutes.push_back(minutes_since_1980);
      end
    end
    mismatches     <= fail_n;
    pending        <= expected_dates.size();
    dates_checked  <= checked_n;
    leap_days_seen <= leap_n;
    december_seen  <= dec_n;
  end

endmodule

[tb/tb.sv]
// Testbench top for the minutes-to-calendar-date unit: clock, reset, stimulus
// and verdict. Depends on minutes_to_calendar_date_unit and the checker module.
module tb;

  localparam int DATE_BITS     = 32;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int PHASE_COUNT   = 4;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 120;
  // Largest four-year cycle index whose every day still fits in 32 bits of minutes.
  localparam int LAST_CYCLE    = 2040;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] minutes_since_1980 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;

  int mismatches;
  int pending;
  int dates_checked;
  int leap_days_seen;
  int december_seen;

  // Percent chances of an idle sender cycle and of a stalled receiver cycle.
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  logic hold_off      = 1'b0;
  logic pressure_go   = 1'b0;
  int   cycle_count   = 0;

  // Hand-picked minute counts: the first and last minute of a day, month ends
  // around February in leap and common years, year and cycle boundaries, the
  // year 2100 that still counts as a leap year, and the extremes of the field.
  logic [31:0] corner_minutes [0:22] = '{
    32'd0, 32'd59, 32'd60, 32'd1439, 32'd1440,
    32'd44639, 32'd44640, 32'd86399, 32'd86400, 32'd482400,
    32'd526320, 32'd527040, 32'd610560, 32'd612000, 32'd1576800,
    32'd2103839, 32'd2103840, 32'd63200160, 32'd63201600,
    32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
  };

  // Days within a four-year cycle that sit on a month or year edge.
  int month_edges [0:19] = '{
    0, 30, 31, 59, 60, 334, 335, 365, 366, 424,
    425, 730, 731, 789, 790, 1095, 1096, 1154, 1155, 1460
  };

  minutes_to_calendar_date_unit #(
    .DATE_BITS(DATE_BITS)
  ) i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .minutes_since_1980 (minutes_since_1980),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .month              (month),
    .day_of_month       (day_of_month),
    .hour               (hour),
    .minute             (minute)
  );

  minutes_to_calendar_date_checker #(
    .DATE_BITS(DATE_BITS)
  ) i_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .minutes_since_1980 (minutes_since_1980),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .month              (month),
    .day_of_month       (day_of_month),
    .hour               (hour),
    .minute             (minute),
    .mismatches         (mismatches),
    .pending            (pending),
    .dates_checked      (dates_checked),
    .leap_days_seen     (leap_days_seen),
    .december_seen      (december_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off if it ever takes far longer than the slowest good run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // The receiver stalls at the rate of the current phase. During a hold-off it
  // refuses every result, so the output register and then the input side fill.
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off, counted in cycles here while the sender keeps offering.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off = 1'b1;
    for (int n = 0; n < HOLD_CYCLES; n++) begin
      @(posedge clk);
    end
    hold_off = 1'b0;
  end

  // Offers one transaction. It is entered at a falling edge and returns at the
  // falling edge after acceptance, so valid stays high between back-to-back
  // transactions and is only lowered when the sender decides to idle.
  task automatic offer_minutes(input logic [31:0] mins);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    minutes_since_1980 <= mins;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] mins;
    logic [31:0] day;
    int          pick;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners first, with neither side idling.
    foreach (corner_minutes[k]) begin
      offer_minutes(corner_minutes[k]);
    end

    // Random part in four phases: free-running, idle sender, stalling receiver,
    // and light idling on both sides with the long hold-off at its start.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 53;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 53;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
          pressure_go   = 1'b1;
        end
      endcase
      repeat (RANDOM_ITEMS / PHASE_COUNT) begin
        // Three in ten are raw 32-bit words so that every input bit toggles;
        // the rest are built from a cycle, a day and a minute of the day, with
        // many days pinned to month and year edges.
        pick = $urandom_range(9);
        if (pick < 3) begin
          mins = $urandom();
        end else begin
          if (pick < 6) begin
            day = month_edges[$urandom_range(19)];
          end else begin
            day = $urandom_range(1460);
          end
          day  = 32'($urandom_range(LAST_CYCLE)) * 32'd1461 + day;
          mins = day * 32'd1440 + 32'($urandom_range(1439));
        end
        offer_minutes(mins);
      end
    end
    in_valid <= 1'b0;

    // Drain every outstanding conversion, then allow time for anything stray.
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d dates checked over directed corners and four idle/stall phases,",
             dates_checked);
    $display("tb: including %0d on February 29 and %0d in December, one long output hold-off",
             leap_days_seen, december_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mtcd_pkg.sv
sv/mtcd_serial_div.sv
sv/minutes_to_calendar_date_unit.sv
tb/minutes_to_calendar_date_checker.sv
tb/tb.sv
